FILE: hw/rtl/cfsc_pkg.sv
package cfsc_pkg;

    localparam int unsigned NUM_BINS = 4;
    localparam int unsigned BIN_W    = 2;
    localparam int unsigned IDX_W    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int unsigned FLAGS_W  = 8;
    localparam int unsigned IN_W     = 48;
    localparam int unsigned OUT_W    = 16;

    localparam logic [7:0] HUM_FULL = 8'd100;

    localparam int unsigned F_LAMP1 = 0;
    localparam int unsigned F_LAMP2 = 1;
    localparam int unsigned F_FAN   = 2;
    localparam int unsigned F_MIST  = 3;
    localparam int unsigned F_DAY   = 4;
    localparam int unsigned F_DEW   = 5;
    localparam int unsigned F_RAIN  = 6;
    localparam int unsigned F_DRY   = 7;

    typedef logic [FLAGS_W-1:0] t_flags;

    typedef struct packed {
        logic [7:0]       humidity_now;
        logic [7:0]       temp_now;
        logic             is_rain;
        logic             is_dew;
        logic             is_day;
        logic [7:0]       humidity_setpoint;
        logic [7:0]       night_temp_setpoint;
        logic [7:0]       day_temp_setpoint;
        logic [BIN_W-1:0] bin;
    } t_step;

    typedef struct packed {
        logic             wr_en;
        logic [BIN_W-1:0] bin;
        t_flags           flags;
    } t_bank_wr;

endpackage

FILE: hw/rtl/cfsc_flag_bank.sv
module cfsc_flag_bank (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [cfsc_pkg::BIN_W-1:0]    i_rd_bin,
    output cfsc_pkg::t_flags              o_rd_flags,
    input  cfsc_pkg::t_bank_wr            i_wr
);

    cfsc_pkg::t_flags r_flags [cfsc_pkg::NUM_BINS];

    logic rd_ok;
    logic wr_ok;

    assign rd_ok = 32'(i_rd_bin) < cfsc_pkg::NUM_BINS;
    assign wr_ok = 32'(i_wr.bin) < cfsc_pkg::NUM_BINS;

    assign o_rd_flags = rd_ok ? r_flags[i_rd_bin[cfsc_pkg::IDX_W-1:0]] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < cfsc_pkg::NUM_BINS; i++) begin
                r_flags[i] <= '0;
            end
        end else if (i_wr.wr_en && wr_ok) begin
            r_flags[i_wr.bin[cfsc_pkg::IDX_W-1:0]] <= i_wr.flags;
        end
    end

endmodule

FILE: hw/rtl/cfsc_rules.sv
module cfsc_rules (
    input  cfsc_pkg::t_step  i_step,
    input  cfsc_pkg::t_flags i_flags,
    output cfsc_pkg::t_flags o_flags
);

    logic       t_gt_n;
    logic       t_lt_n;
    logic       h_gt_s;
    logic       t_gt_d;
    logic       t_lt_d;
    logic [7:0] t;
    logic [7:0] h;

    assign t      = i_step.temp_now;
    assign h      = i_step.humidity_now;
    assign t_gt_n = t > i_step.night_temp_setpoint;
    assign t_lt_n = t < i_step.night_temp_setpoint;
    assign h_gt_s = h > i_step.humidity_setpoint;
    assign t_gt_d = t > i_step.day_temp_setpoint;
    assign t_lt_d = t < i_step.day_temp_setpoint;

    always_comb begin
        cfsc_pkg::t_flags f;
        f = i_flags;

        // light
        if (!f[cfsc_pkg::F_DAY] && i_step.is_day) begin
            f[cfsc_pkg::F_DAY]   = 1'b1;
            f[cfsc_pkg::F_LAMP1] = 1'b1;
            f[cfsc_pkg::F_LAMP2] = 1'b1;
        end
        if (f[cfsc_pkg::F_DAY] && !i_step.is_day) begin
            f[cfsc_pkg::F_DAY]   = 1'b0;
            f[cfsc_pkg::F_LAMP1] = 1'b0;
            f[cfsc_pkg::F_LAMP2] = 1'b0;
        end

        // dew
        if (!f[cfsc_pkg::F_DEW] && i_step.is_dew) begin
            if (!f[cfsc_pkg::F_MIST] && t_gt_n) begin
                f[cfsc_pkg::F_MIST] = 1'b1;
                f[cfsc_pkg::F_DEW]  = 1'b1;
            end
            if (!f[cfsc_pkg::F_FAN] && t_gt_n) begin
                f[cfsc_pkg::F_FAN] = 1'b1;
            end
        end
        if (f[cfsc_pkg::F_DEW] && (i_step.is_dew || t_gt_n)) begin
            if (f[cfsc_pkg::F_MIST] && h_gt_s) begin
                f[cfsc_pkg::F_MIST] = 1'b0;
            end
            f[cfsc_pkg::F_FAN] = 1'b0;
            f[cfsc_pkg::F_DEW] = 1'b0;
        end

        // rain cloud
        if (!f[cfsc_pkg::F_RAIN] && i_step.is_rain && (h < cfsc_pkg::HUM_FULL)) begin
            if (!f[cfsc_pkg::F_MIST] && t_gt_n) begin
                f[cfsc_pkg::F_MIST] = 1'b1;
                f[cfsc_pkg::F_RAIN] = 1'b1;
            end
            f[cfsc_pkg::F_LAMP2] = 1'b0;
        end
        if (f[cfsc_pkg::F_RAIN] && (!i_step.is_rain || t_lt_n)) begin
            f[cfsc_pkg::F_RAIN] = 1'b0;
            if (f[cfsc_pkg::F_MIST] && h_gt_s) begin
                f[cfsc_pkg::F_MIST] = 1'b0;
            end
            if (!f[cfsc_pkg::F_LAMP2] && i_step.is_day) begin
                f[cfsc_pkg::F_LAMP2] = 1'b1;
            end
        end

        // humidity
        if (!f[cfsc_pkg::F_DRY] && (h < i_step.humidity_setpoint) && t_gt_n) begin
            f[cfsc_pkg::F_DRY]  = 1'b1;
            f[cfsc_pkg::F_MIST] = 1'b1;
        end
        if (f[cfsc_pkg::F_MIST] && !f[cfsc_pkg::F_DEW] && !f[cfsc_pkg::F_RAIN]
            && (h_gt_s || t_lt_n || (h > cfsc_pkg::HUM_FULL))) begin
            f[cfsc_pkg::F_DRY]  = 1'b0;
            f[cfsc_pkg::F_MIST] = 1'b0;
        end
        if (f[cfsc_pkg::F_DRY] && h_gt_s) begin
            f[cfsc_pkg::F_DRY] = 1'b0;
        end
        if (h_gt_s && t_gt_n) begin
            f[cfsc_pkg::F_DRY] = 1'b0;
            f[cfsc_pkg::F_FAN] = 1'b1;
        end

        // temperature
        if (t_gt_d) begin
            f[cfsc_pkg::F_FAN]   = 1'b1;
            f[cfsc_pkg::F_MIST]  = 1'b1;
            f[cfsc_pkg::F_LAMP2] = 1'b0;
        end
        if (t_lt_d) begin
            if (f[cfsc_pkg::F_FAN] && !f[cfsc_pkg::F_DEW]) begin
                f[cfsc_pkg::F_FAN] = 1'b0;
            end
            if (!f[cfsc_pkg::F_LAMP2] && !f[cfsc_pkg::F_RAIN] && f[cfsc_pkg::F_DAY]) begin
                f[cfsc_pkg::F_LAMP2] = 1'b1;
            end
            if (f[cfsc_pkg::F_MIST] && !f[cfsc_pkg::F_DEW] && !f[cfsc_pkg::F_RAIN]
                && !f[cfsc_pkg::F_DRY]) begin
                f[cfsc_pkg::F_MIST] = 1'b0;
            end
        end

        o_flags = f;
    end

endmodule

FILE: hw/rtl/greenhouse_climate_switch_controller.sv
// Channel | Dir | Handshake           | Word
// s       | in  | i_s_tvalid/o_s_tready | one control step for one bin
// m       | out | o_m_tvalid/i_m_tready | updated flags of that bin
//
// One word per cycle sustained while the output is not stalled.
// The flag update for a bin is written when its step moves from the input register
// to the output register, so the next step for the same bin sees it at once.
// Reset clears all bin flags and both valid bits.
// A stalled output holds its word; the input register still takes one more word.
module greenhouse_climate_switch_controller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // bin[1:0], day_temp_setpoint[9:2], night_temp_setpoint[17:10],
    // humidity_setpoint[25:18], is_day[26], is_dew[27], is_rain[28],
    // temp_now[36:29], humidity_now[44:37], zero[47:45]
    input  logic [cfsc_pkg::IN_W-1:0]     i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // bin_out[1:0], lamp1_on[2], lamp2_on[3], fan_on[4], mister_on[5],
    // day_mode[6], dew_active[7], rain_active[8], air_dry[9], zero[15:10]
    output logic [cfsc_pkg::OUT_W-1:0]    o_m_tdata
);

    logic                           r_in_vld;
    cfsc_pkg::t_step                r_in_step;
    logic                           r_out_vld;
    logic [cfsc_pkg::BIN_W-1:0]     r_out_bin;
    cfsc_pkg::t_flags               r_out_flags;

    logic                           advance;
    cfsc_pkg::t_flags               cur_flags;
    cfsc_pkg::t_flags               new_flags;
    cfsc_pkg::t_bank_wr             bank_wr;

    assign advance    = r_in_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_in_vld || advance;

    assign bank_wr.wr_en = advance;
    assign bank_wr.bin   = r_in_step.bin;
    assign bank_wr.flags = new_flags;

    cfsc_flag_bank u_bank (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_bin   (r_in_step.bin),
        .o_rd_flags (cur_flags),
        .i_wr       (bank_wr)
    );

    cfsc_rules u_rules (
        .i_step  (r_in_step),
        .i_flags (cur_flags),
        .o_flags (new_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_vld <= i_s_tvalid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_step <= cfsc_pkg::t_step'(i_s_tdata[$bits(cfsc_pkg::t_step)-1:0]);
        end
        if (advance) begin
            r_out_bin   <= r_in_step.bin;
            r_out_flags <= new_flags;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {
        {(cfsc_pkg::OUT_W - cfsc_pkg::FLAGS_W - cfsc_pkg::BIN_W){1'b0}},
        r_out_flags,
        r_out_bin
    };

endmodule

FILE: sim/tb_top.sv
module tb_top;

    localparam int STEP_COUNT   = 1350;
    localparam int DIRECT_COUNT = 20;
    localparam int IDLE_PCT     = 26;
    localparam int HOLD_CYCLES  = 300;
    localparam int WATCH_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4;

    typedef struct packed {
        logic [cfsc_pkg::BIN_W-1:0] bin;
        cfsc_pkg::t_flags           flags;
    } t_bin_flags;

    typedef struct packed {
        cfsc_pkg::t_step  step;
        logic             typed;
        cfsc_pkg::t_flags flags;
    } t_row;

    logic                       i_clk      = 1'b0;
    logic                       i_rst_n    = 1'b0;
    logic                       i_s_tvalid = 1'b0;
    logic [cfsc_pkg::IN_W-1:0]  i_s_tdata  = '0;
    logic                       i_m_tready = 1'b0;
    logic                       o_s_tready;
    logic                       o_m_tvalid;
    logic [cfsc_pkg::OUT_W-1:0] o_m_tdata;

    cfsc_pkg::t_flags flag_store [cfsc_pkg::NUM_BINS];
    t_bin_flags       flags_due [$];
    int               steps_sent   = 0;
    int               words_seen   = 0;
    int               mismatches   = 0;
    int               stall_cycles = 0;
    int               hold_left    = 0;
    bit               hold_req     = 1'b0;
    bit               quiet        = 1'b0;

    string flag_label [cfsc_pkg::FLAGS_W] = '{"lamp1_on", "lamp2_on", "fan_on", "mister_on",
                                              "day_mode", "dew_active", "rain_active",
                                              "air_dry"};

    greenhouse_climate_switch_controller dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic cfsc_pkg::t_step mk_step(input int bin, input int dts, input int nts,
                                                input int hs, input bit day, input bit dew,
                                                input bit rain, input int t, input int h);
        cfsc_pkg::t_step s;
        s.bin                 = bin[cfsc_pkg::BIN_W-1:0];
        s.day_temp_setpoint   = dts[7:0];
        s.night_temp_setpoint = nts[7:0];
        s.humidity_setpoint   = hs[7:0];
        s.is_day              = day;
        s.is_dew              = dew;
        s.is_rain             = rain;
        s.temp_now            = t[7:0];
        s.humidity_now        = h[7:0];
        return s;
    endfunction

    function automatic logic [7:0] near_byte(input int c);
        int v;
        v = c + int'($urandom_range(6)) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    function automatic cfsc_pkg::t_flags climate_update(input cfsc_pkg::t_flags cur,
                                                        input cfsc_pkg::t_step s);
        cfsc_pkg::t_flags f;
        logic [7:0]       t;
        logic [7:0]       h;
        logic [7:0]       dts;
        logic [7:0]       nts;
        logic [7:0]       hs;
        f   = cur;
        t   = s.temp_now;
        h   = s.humidity_now;
        dts = s.day_temp_setpoint;
        nts = s.night_temp_setpoint;
        hs  = s.humidity_setpoint;

        // light
        if (!f[cfsc_pkg::F_DAY] && s.is_day) begin
            f[cfsc_pkg::F_DAY] = 1'b1; f[cfsc_pkg::F_LAMP1] = 1'b1; f[cfsc_pkg::F_LAMP2] = 1'b1;
        end
        if (f[cfsc_pkg::F_DAY] && !s.is_day) begin
            f[cfsc_pkg::F_DAY] = 1'b0; f[cfsc_pkg::F_LAMP1] = 1'b0; f[cfsc_pkg::F_LAMP2] = 1'b0;
        end

        // dew: an episode that starts here also ends here
        if (!f[cfsc_pkg::F_DEW] && s.is_dew) begin
            if (!f[cfsc_pkg::F_MIST] && t > nts) begin
                f[cfsc_pkg::F_MIST] = 1'b1; f[cfsc_pkg::F_DEW] = 1'b1;
            end
            if (!f[cfsc_pkg::F_FAN] && t > nts) f[cfsc_pkg::F_FAN] = 1'b1;
        end
        if (f[cfsc_pkg::F_DEW] && (s.is_dew || t > nts)) begin
            if (f[cfsc_pkg::F_MIST] && h > hs) f[cfsc_pkg::F_MIST] = 1'b0;
            f[cfsc_pkg::F_FAN] = 1'b0; f[cfsc_pkg::F_DEW] = 1'b0;
        end

        // rain cloud
        if (!f[cfsc_pkg::F_RAIN] && s.is_rain && h < cfsc_pkg::HUM_FULL) begin
            if (!f[cfsc_pkg::F_MIST] && t > nts) begin
                f[cfsc_pkg::F_MIST] = 1'b1; f[cfsc_pkg::F_RAIN] = 1'b1;
            end
            f[cfsc_pkg::F_LAMP2] = 1'b0;
        end
        if (f[cfsc_pkg::F_RAIN] && (!s.is_rain || t < nts)) begin
            f[cfsc_pkg::F_RAIN] = 1'b0;
            if (f[cfsc_pkg::F_MIST] && h > hs) f[cfsc_pkg::F_MIST] = 1'b0;
            if (!f[cfsc_pkg::F_LAMP2] && s.is_day) f[cfsc_pkg::F_LAMP2] = 1'b1;
        end

        // humidity
        if (!f[cfsc_pkg::F_DRY] && h < hs && t > nts) begin
            f[cfsc_pkg::F_DRY] = 1'b1; f[cfsc_pkg::F_MIST] = 1'b1;
        end
        if (f[cfsc_pkg::F_MIST] && !f[cfsc_pkg::F_DEW] && !f[cfsc_pkg::F_RAIN]
            && (h > hs || t < nts || h > cfsc_pkg::HUM_FULL)) begin
            f[cfsc_pkg::F_DRY] = 1'b0; f[cfsc_pkg::F_MIST] = 1'b0;
        end
        if (f[cfsc_pkg::F_DRY] && h > hs) f[cfsc_pkg::F_DRY] = 1'b0;
        if (h > hs && t > nts) begin
            f[cfsc_pkg::F_DRY] = 1'b0; f[cfsc_pkg::F_FAN] = 1'b1;
        end

        // temperature
        if (t > dts) begin
            f[cfsc_pkg::F_FAN] = 1'b1; f[cfsc_pkg::F_MIST] = 1'b1; f[cfsc_pkg::F_LAMP2] = 1'b0;
        end
        if (t < dts) begin
            if (f[cfsc_pkg::F_FAN] && !f[cfsc_pkg::F_DEW]) f[cfsc_pkg::F_FAN] = 1'b0;
            if (!f[cfsc_pkg::F_LAMP2] && !f[cfsc_pkg::F_RAIN] && f[cfsc_pkg::F_DAY])
                f[cfsc_pkg::F_LAMP2] = 1'b1;
            if (f[cfsc_pkg::F_MIST] && !f[cfsc_pkg::F_DEW] && !f[cfsc_pkg::F_RAIN]
                && !f[cfsc_pkg::F_DRY])
                f[cfsc_pkg::F_MIST] = 1'b0;
        end
        return f;
    endfunction

    task automatic send_step(input cfsc_pkg::t_step s, input logic typed,
                             input cfsc_pkg::t_flags flags_typed);
        cfsc_pkg::t_flags cur;
        cfsc_pkg::t_flags nxt;
        t_bin_flags       due;
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(cfsc_pkg::IN_W - $bits(cfsc_pkg::t_step)){1'b0}}, s};
        do @(posedge i_clk); while (!o_s_tready);
        cur = (s.bin < cfsc_pkg::NUM_BINS) ? flag_store[s.bin] : '0;
        nxt = climate_update(cur, s);
        if (s.bin < cfsc_pkg::NUM_BINS) flag_store[s.bin] = nxt;
        due.bin   = s.bin;
        due.flags = typed ? flags_typed : nxt;
        flags_due.push_back(due);
        steps_sent++;
    endtask

    // drive, predict
    initial begin : step_source
        t_row            rows [DIRECT_COUNT];
        logic [7:0]      set_dts [cfsc_pkg::NUM_BINS];
        logic [7:0]      set_nts [cfsc_pkg::NUM_BINS];
        logic [7:0]      set_hs [cfsc_pkg::NUM_BINS];
        bit              want_day [cfsc_pkg::NUM_BINS];
        bit              want_rain [cfsc_pkg::NUM_BINS];
        cfsc_pkg::t_step s;
        logic [63:0]     noise;
        int              b;
        int              pick;

        rows[0]  = '{mk_step(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 8'h00};
        rows[1]  = '{mk_step(1, 255, 255, 255, 1, 1, 1, 255, 255), 1'b1, 8'h13};
        rows[2]  = '{mk_step(2, 0, 0, 0, 0, 0, 0, 255, 0), 1'b1, 8'h0C};
        rows[3]  = '{mk_step(3, 255, 0, 0, 0, 0, 0, 0, 0), 1'b1, 8'h00};
        rows[4]  = '{mk_step(0, 30, 10, 60, 1, 0, 0, 20, 50), 1'b0, 8'h00};
        rows[5]  = '{mk_step(0, 30, 10, 60, 1, 1, 0, 20, 50), 1'b0, 8'h00};
        rows[6]  = '{mk_step(0, 30, 10, 60, 1, 0, 1, 20, 50), 1'b0, 8'h00};
        rows[7]  = '{mk_step(0, 30, 10, 60, 1, 0, 1, 20, 70), 1'b0, 8'h00};
        rows[8]  = '{mk_step(1, 50, 10, 60, 1, 0, 1, 40, 99), 1'b0, 8'h00};
        rows[9]  = '{mk_step(1, 50, 10, 60, 1, 0, 1, 5, 99), 1'b0, 8'h00};
        rows[10] = '{mk_step(1, 50, 10, 100, 1, 0, 0, 20, 100), 1'b0, 8'h00};
        rows[11] = '{mk_step(1, 50, 10, 150, 0, 0, 0, 20, 101), 1'b0, 8'h00};
        rows[12] = '{mk_step(2, 40, 10, 60, 1, 0, 1, 40, 60), 1'b0, 8'h00};
        rows[13] = '{mk_step(2, 40, 10, 60, 0, 0, 0, 40, 60), 1'b0, 8'h00};
        rows[14] = '{mk_step(3, 255, 0, 0, 0, 0, 0, 255, 255), 1'b0, 8'h00};
        rows[15] = '{mk_step(3, 30, 10, 100, 1, 1, 0, 11, 200), 1'b0, 8'h00};
        rows[16] = '{mk_step(3, 30, 10, 100, 1, 1, 0, 10, 200), 1'b0, 8'h00};
        rows[17] = '{mk_step(2, 255, 0, 255, 1, 0, 1, 255, 0), 1'b0, 8'h00};
        rows[18] = '{mk_step(2, 255, 0, 255, 1, 0, 1, 0, 0), 1'b0, 8'h00};
        rows[19] = '{mk_step(0, 0, 255, 0, 0, 0, 0, 0, 0), 1'b0, 8'h00};

        for (int i = 0; i < cfsc_pkg::NUM_BINS; i++) begin
            flag_store[i] = '0;
            set_nts[i]    = 8'($urandom_range(5, 40));
            set_dts[i]    = set_nts[i] + 8'($urandom_range(20));
            set_hs[i]     = 8'($urandom_range(20, 110));
            want_day[i]   = 1'b0;
            want_rain[i]  = 1'b0;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIRECT_COUNT; i++)
            send_step(rows[i].step, rows[i].typed, rows[i].flags);

        for (int n = 0; n < STEP_COUNT; n++) begin
            quiet = (n >= 200 && n < 420);
            if (n == 600) hold_req = 1'b1;
            if (n == 900) begin
                i_s_tvalid <= 1'b0;
                while (flags_due.size() != 0) @(posedge i_clk);
            end

            b = $urandom_range(cfsc_pkg::NUM_BINS - 1);
            if ($urandom_range(19) == 0) begin
                if ($urandom_range(3) == 0) begin
                    set_nts[b] = 8'($urandom);
                    set_dts[b] = 8'($urandom);
                    set_hs[b]  = 8'($urandom);
                end else begin
                    set_nts[b] = 8'($urandom_range(5, 40));
                    set_dts[b] = set_nts[b] + 8'($urandom_range(20));
                    set_hs[b]  = 8'($urandom_range(20, 110));
                end
            end
            if ($urandom_range(9) == 0) want_day[b] = !want_day[b];
            if ($urandom_range(7) == 0) want_rain[b] = !want_rain[b];

            s.bin                 = b[cfsc_pkg::BIN_W-1:0];
            s.day_temp_setpoint   = set_dts[b];
            s.night_temp_setpoint = set_nts[b];
            s.humidity_setpoint   = set_hs[b];
            s.is_day              = want_day[b];
            s.is_dew              = ($urandom_range(5) == 0);
            s.is_rain             = want_rain[b];

            pick = $urandom_range(9);
            if (pick < 4)       s.temp_now = near_byte(set_nts[b]);
            else if (pick < 7)  s.temp_now = near_byte(set_dts[b]);
            else if (pick < 9)  s.temp_now = 8'($urandom);
            else                s.temp_now = $urandom_range(1) ? 8'hFF : 8'h00;

            pick = $urandom_range(9);
            if (pick < 4)       s.humidity_now = near_byte(set_hs[b]);
            else if (pick < 6)  s.humidity_now = near_byte(cfsc_pkg::HUM_FULL);
            else if (pick < 9)  s.humidity_now = 8'($urandom);
            else                s.humidity_now = $urandom_range(1) ? 8'hFF : 8'h00;

            if ($urandom_range(9) == 0) begin
                noise = {$urandom, $urandom};
                s     = noise[$bits(cfsc_pkg::t_step)-1:0];
            end
            send_step(s, 1'b0, '0);
        end

        i_s_tvalid <= 1'b0;
        while (flags_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d control steps sent (%0d directed) over all %0d bins, %0d words checked",
                 steps_sent, DIRECT_COUNT, cfsc_pkg::NUM_BINS, words_seen);
        $display("day, dew and rain episodes mixed with noise; one long output stall, one drain");
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // accept, compare, stall
    always @(posedge i_clk) begin : flag_sink
        t_bin_flags want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            words_seen++;
            if (flags_due.size() == 0) begin
                mismatches++;
                $display("%0t: word with nothing expected: actual %h", $time, o_m_tdata);
            end else begin
                want = flags_due.pop_front();
                if (o_m_tdata[cfsc_pkg::BIN_W-1:0] !== want.bin) begin
                    mismatches++;
                    $display("%0t: bin_out expected %0d actual %0d",
                             $time, want.bin, o_m_tdata[cfsc_pkg::BIN_W-1:0]);
                end
                for (int k = 0; k < cfsc_pkg::FLAGS_W; k++) begin
                    if (o_m_tdata[cfsc_pkg::BIN_W+k] !== want.flags[k]) begin
                        mismatches++;
                        $display("%0t: bin %0d %s expected %b actual %b", $time, want.bin,
                                 flag_label[k], want.flags[k], o_m_tdata[cfsc_pkg::BIN_W+k]);
                    end
                end
            end
        end
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCH_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, WATCH_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule

FILE: sim.f
hw/rtl/cfsc_pkg.sv
hw/rtl/cfsc_flag_bank.sv
hw/rtl/cfsc_rules.sv
hw/rtl/greenhouse_climate_switch_controller.sv
sim/tb_top.sv
